@@ design/assert_macros.svh @@
// Assertion helpers used by greedy_box_nms_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, inactive while reset is held.
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check with reset not masked.
`define GBN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the greedy box suppression unit.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int GBN_MAX_KEPT = 64;
  localparam logic [8:0] GBN_THR_RESET = 9'd115;

  typedef struct packed {
    logic              first_box;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_w;
    logic [14:0]        box_h;
  } box_in_t;

  typedef struct packed {
    logic       keep;
    logic [6:0] kept_slot;
    logic       list_overflow;
  } result_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [29:0]        area;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic hit;
  } pipe_stat_t;

endpackage

@@ design/gbn_iou_pipe.sv @@
// ----------------------------------------------------------------------------
// gbn_iou_pipe
// Four-stage overlap test of the candidate box against one stored box per
// cycle; the multiplier for the intersection area also forms the candidate area.
// ----------------------------------------------------------------------------
module gbn_iou_pipe import gbn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  box_in_t    cand,
  input  logic       area_req,
  input  logic [8:0] thr,
  input  logic       ent_valid,
  input  entry_t     ent,
  output logic [29:0] cand_area,
  output pipe_stat_t stat
);

  logic signed [17:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
  logic signed [17:0] xlo, xhi, ylo, yhi, xdif, ydif;
  logic [14:0] iw, ih;

  logic        s1_valid, s2_valid, s3_valid, s4_valid;
  logic [14:0] s1_iw, s1_ih;
  logic [29:0] s1_karea, s2_karea, s2_inter, s3_inter;
  logic [30:0] s3_uni;
  logic        s4_hit;

  logic [14:0] mul_a, mul_b;
  logic [29:0] prod;
  logic [31:0] uni_sum;
  logic [39:0] lhs, rhs;

  // Edges in 18 bits so that left + width never wraps.
  always_comb begin
    ax0 = 18'(cand.box_x);
    ax1 = ax0 + $signed({3'b000, cand.box_w});
    bx0 = 18'(ent.left);
    bx1 = bx0 + $signed({3'b000, ent.width});
    ay0 = 18'(cand.box_y);
    ay1 = ay0 + $signed({3'b000, cand.box_h});
    by0 = 18'(ent.top);
    by1 = by0 + $signed({3'b000, ent.height});
    xlo = (ax0 > bx0) ? ax0 : bx0;
    xhi = (ax1 < bx1) ? ax1 : bx1;
    ylo = (ay0 > by0) ? ay0 : by0;
    yhi = (ay1 < by1) ? ay1 : by1;
    xdif = xhi - xlo;
    ydif = yhi - ylo;
    iw = (xhi > xlo) ? xdif[14:0] : '0;
    ih = (yhi > ylo) ? ydif[14:0] : '0;
  end

  // The multiplier serves the candidate area before the scan starts.
  assign mul_a = area_req ? cand.box_w : s1_iw;
  assign mul_b = area_req ? cand.box_h : s1_ih;
  assign prod  = mul_a * mul_b;

  assign uni_sum = {2'b00, cand_area} + {2'b00, s2_karea} - {2'b00, s2_inter};
  assign lhs = {2'b00, s3_inter, 8'h00};
  assign rhs = thr * s3_uni;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= ent_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (area_req) begin
      cand_area <= prod;
    end
    s1_iw    <= iw;
    s1_ih    <= ih;
    s1_karea <= ent.area;
    s2_inter <= prod;
    s2_karea <= s1_karea;
    s3_inter <= s2_inter;
    s3_uni   <= uni_sum[30:0];
    s4_hit   <= lhs > rhs;
  end

  assign stat.empty = !(s1_valid || s2_valid || s3_valid || s4_valid);
  assign stat.hit   = s4_valid && s4_hit;

endmodule

@@ design/greedy_box_nms_unit.sv @@
// A box passes through the area, scan, flush and done states before the done
// strobe; one stored box goes through the overlap pipeline per cycle, read from
// the kept-box memory. busy stays high for the whole item, so a new box is
// taken only once the unit is idle again. Synchronous reset empties the kept
// list and loads the threshold with 115; the receiver cannot stall.
// ----------------------------------------------------------------------------
// greedy_box_nms_unit
// Greedy non-maximum suppression of score-ordered boxes against a kept list.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module greedy_box_nms_unit import gbn_pkg::*; #(
  parameter int MAX_KEPT = GBN_MAX_KEPT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  box_in_t    box,
  output logic       busy,
  output logic       done,
  output result_t    result,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data
);

  localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W = $clog2(MAX_KEPT + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_AREA  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [8:0]  thr;
  box_in_t     cand;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_idx;
  logic        suppress;
  logic        rd_valid;
  entry_t      rd_data;
  entry_t      kept_mem [MAX_KEPT];
  logic [29:0] cand_area;
  pipe_stat_t  stat;
  logic        accept, issue, has_room, keep_now;
  logic [31:0] count_wide;
  entry_t      new_entry;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign issue    = (state == S_SCAN) && (scan_idx < count);
  assign has_room = count < CNT_W'(MAX_KEPT);
  assign keep_now = !suppress;
  assign count_wide = 32'(count);

  always_comb begin
    new_entry.left   = cand.box_x;
    new_entry.top    = cand.box_y;
    new_entry.width  = cand.box_w;
    new_entry.height = cand.box_h;
    new_entry.area   = cand_area;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_AREA;
      S_AREA:  state_next = S_SCAN;
      S_SCAN:  if (!issue) state_next = S_FLUSH;
      S_FLUSH: if (!rd_valid && stat.empty) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      thr      <= GBN_THR_RESET;
      count    <= '0;
      scan_idx <= '0;
      suppress <= 1'b0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      done     <= (state == S_DONE);
      if (cfg_wr_en) begin
        thr <= cfg_wr_data;
      end
      if (accept) begin
        scan_idx <= '0;
        suppress <= 1'b0;
        // A new set starts with an empty kept list.
        if (box.first_box) begin
          count <= '0;
        end
      end
      if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (stat.hit) begin
        suppress <= 1'b1;
      end
      if ((state == S_DONE) && keep_now && has_room) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cand <= box;
    end
    if (state == S_DONE) begin
      result.keep          <= keep_now;
      result.kept_slot     <= (keep_now && has_room) ? count_wide[6:0] :
                              keep_now ? 7'(MAX_KEPT) : 7'd0;
      result.list_overflow <= keep_now && !has_room;
    end
  end

  // Kept-box memory: written once per kept box that fits, read once per scan step.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && keep_now && has_room) begin
      kept_mem[count[IDX_W-1:0]] <= new_entry;
    end
    if (issue) begin
      rd_data <= kept_mem[scan_idx[IDX_W-1:0]];
    end
  end

  gbn_iou_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cand      (cand),
    .area_req  (state == S_AREA),
    .thr       (thr),
    .ent_valid (rd_valid),
    .ent       (rd_data),
    .cand_area (cand_area),
    .stat      (stat)
  );

  `GBN_ASSERT(a_count_bound, count <= CNT_W'(MAX_KEPT), "kept count above capacity")
  `GBN_ASSERT(a_done_src, done |-> $past(state == S_DONE), "done without a finished box")
  `GBN_ASSERT(a_idle_empty, (state == S_IDLE) |-> (stat.empty && !rd_valid),
              "overlap pipeline busy while idle")
  `GBN_ASSERT(a_ovf_keep, (done && result.list_overflow) |-> result.keep,
              "overflow flagged on a suppressed box")

endmodule
